FILE: hdl/sorc_pkg.sv
// Shared types, constants and helpers for the segment overlap raster counter.
package sorc_pkg;

    // Coordinate width of one end point and width of the running total.
    localparam int unsigned COORD_W       = 10;
    localparam int unsigned COUNT_W       = 21;
    localparam int unsigned HIT_W         = 2;
    localparam int unsigned GRID_SIDE_DEF = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [HIT_W-1:0]   HIT_MAX     = '1;
    localparam logic [HIT_W-1:0]   HIT_OVERLAP = HIT_W'(2);

    // Control sequence of the block.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_DRAW,
        S_DRAIN,
        S_DONE
    } t_state;

    // Step direction along one axis.
    typedef enum logic [1:0] {
        DIR_HOLD,
        DIR_INC,
        DIR_DEC
    } t_dir;

    // Command from the sequencer to the cell walker.
    typedef struct packed {
        logic               load;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_dir               dir_x;
        t_dir               dir_y;
        logic [COORD_W-1:0] len;
    } t_walk_cmd;

    // Status of the cell walker.
    typedef struct packed {
        logic issue;
        logic last;
    } t_walk_stat;

    // Moves a coordinate one cell in the given direction.
    function automatic logic [COORD_W-1:0] f_step(input logic [COORD_W-1:0] c, input t_dir d);
        logic [COORD_W-1:0] r;
        case (d)
            DIR_INC: r = c + 1'b1;
            DIR_DEC: r = c - 1'b1;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/sorc_intf.sv
// Channel interfaces: segment input and overlap result output.
interface sorc_seg_if
    import sorc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface sorc_res_if
    import sorc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] overlap_count;
    logic               bad_segment;

    modport source (output valid, overlap_count, bad_segment, input ready);
    modport sink (input valid, overlap_count, bad_segment, output ready);
endinterface

FILE: hdl/segment_overlap_raster_counter.sv
// Top level of the segment overlap raster counter.
// Usage:
// - i_seg carries one segment per transaction (start_x, start_y, end_x, end_y).
//   The segment may be horizontal, vertical, at 45 degrees or a single point.
// - o_res returns one transaction per segment: the number of grid cells hit at
//   least twice so far, and bad_segment for a segment of another slope or one
//   that leaves the grid; such a segment changes nothing.
// - A new segment is accepted only once the previous one has been drawn, its
//   last cell written back and its result loaded into the output register; a
//   bad segment is not drawn. The grid memory does one read-modify-write of a
//   cell per cycle while a segment is drawn.
// - After reset the grid memory is swept to zero, one cell per cycle, over all
//   2**(2*ceil(log2(GRID_SIDE))) cells for GRID_SIDE up to 1024; i_seg.ready
//   stays low meanwhile.
// - The result sits in an output register. A new segment is accepted while a
//   result waits; the block only holds when a further result is ready and the
//   receiver has not yet taken the previous one.
module segment_overlap_raster_counter
    import sorc_pkg::*;
#(
    parameter int unsigned GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sorc_seg_if.sink  i_seg,
    sorc_res_if.source o_res
);

    localparam int unsigned CW = ($clog2(GRID_SIDE) < COORD_W) ? $clog2(GRID_SIDE) : COORD_W;
    localparam int unsigned AW = 2 * CW;

    t_state             r_state;
    t_state             n_state;
    logic [AW-1:0]      r_clr_addr;
    logic [COORD_W-1:0] r_x1;
    logic [COORD_W-1:0] r_y1;
    logic [COORD_W-1:0] r_x2;
    logic [COORD_W-1:0] r_y2;
    logic               r_bad;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_bad;

    logic [COORD_W-1:0] w_dx;
    logic [COORD_W-1:0] w_dy;
    logic               w_off_grid;
    logic               w_bad;
    logic               w_out_free;
    logic               w_in_ready;
    logic               w_clearing;
    logic               w_out_load;
    t_walk_cmd          w_cmd;
    t_walk_stat         w_stat;
    logic [AW-1:0]      w_walk_addr;
    logic [HIT_W-1:0]   w_rd_data;
    logic               w_upd_wr_en;
    logic [AW-1:0]      w_upd_wr_addr;
    logic [HIT_W-1:0]   w_upd_wr_data;
    logic [COUNT_W-1:0] w_count;
    logic               w_mem_wr_en;
    logic [AW-1:0]      w_mem_wr_addr;
    logic [HIT_W-1:0]   w_mem_wr_data;

    // Segment classification from the captured end points.
    always_comb begin
        w_dx = (r_x1 > r_x2) ? (r_x1 - r_x2) : (r_x2 - r_x1);
        w_dy = (r_y1 > r_y2) ? (r_y1 - r_y2) : (r_y2 - r_y1);
        w_off_grid = (32'(r_x1) >= GRID_SIDE) || (32'(r_x2) >= GRID_SIDE) ||
                     (32'(r_y1) >= GRID_SIDE) || (32'(r_y2) >= GRID_SIDE);
        w_bad = w_off_grid || ((w_dx != '0) && (w_dy != '0) && (w_dx != w_dy));
    end

    // Walk command built from the end points.
    always_comb begin
        w_cmd.x     = r_x1;
        w_cmd.y     = r_y1;
        w_cmd.len   = (w_dx > w_dy) ? w_dx : w_dy;
        w_cmd.dir_x = (r_x2 > r_x1) ? DIR_INC : ((r_x2 < r_x1) ? DIR_DEC : DIR_HOLD);
        w_cmd.dir_y = (r_y2 > r_y1) ? DIR_INC : ((r_y2 < r_y1) ? DIR_DEC : DIR_HOLD);
        w_cmd.load  = (r_state == S_SETUP) && !w_bad;
    end

    assign w_out_free = !r_out_valid || o_res.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == '1) n_state = S_IDLE;
            S_IDLE:  if (i_seg.valid) n_state = S_SETUP;
            S_SETUP: n_state = w_bad ? S_DONE : S_DRAW;
            S_DRAW:  if (w_stat.last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // State outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_clearing = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_CLEAR: w_clearing = 1'b1;
            S_IDLE:  w_in_ready = 1'b1;
            S_DONE:  w_out_load = w_out_free;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (w_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Capture the segment on an input transaction; keep the verdict for the result.
    always_ff @(posedge i_clk) begin
        if (i_seg.valid && w_in_ready) begin
            r_x1 <= i_seg.start_x;
            r_y1 <= i_seg.start_y;
            r_x2 <= i_seg.end_x;
            r_y2 <= i_seg.end_y;
        end
        if (r_state == S_SETUP) begin
            r_bad <= w_bad;
        end
    end

    assign i_seg.ready = w_in_ready;

    sorc_walker #(
        .CW (CW)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_addr  (w_walk_addr)
    );

    sorc_update #(
        .AW (AW)
    ) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (w_stat.issue),
        .i_addr    (w_walk_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_upd_wr_en),
        .o_wr_addr (w_upd_wr_addr),
        .o_wr_data (w_upd_wr_data),
        .o_count   (w_count)
    );

    // The clearing sweep takes the write port until it finishes.
    assign w_mem_wr_en   = w_clearing || w_upd_wr_en;
    assign w_mem_wr_addr = w_clearing ? r_clr_addr : w_upd_wr_addr;
    assign w_mem_wr_data = w_clearing ? '0 : w_upd_wr_data;

    sorc_grid_mem #(
        .AW (AW)
    ) u_grid_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_stat.issue),
        .i_rd_addr (w_walk_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_count <= w_count;
            r_out_bad   <= r_bad;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.overlap_count = r_out_count;
    assign o_res.bad_segment   = r_out_bad;

    // Grid reads are only issued while a segment is being drawn.
    a_issue_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.issue |-> (r_state == S_DRAW))
        else $error("grid read issued outside the draw phase");

    // A write never lands on the cell being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.issue && w_mem_wr_en) |-> (w_mem_wr_addr != w_walk_addr))
        else $error("grid read and write address clash");

    // A new segment is taken only when no cell update is still in flight.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> (!w_stat.issue && !w_upd_wr_en && !w_clearing))
        else $error("segment accepted while grid still busy");

    // A bad segment leaves the running total unchanged.
    a_bad_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SETUP) && w_bad) |=> (w_count == $past(w_count)))
        else $error("running total moved on a rejected segment");

endmodule

FILE: hdl/sorc_grid_mem.sv
// Grid memory of 2-bit hit counters with one registered read port and one write port.
module sorc_grid_mem
    import sorc_pkg::*;
#(
    parameter int unsigned AW = 20
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [HIT_W-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [HIT_W-1:0] i_wr_data
);

    logic [HIT_W-1:0] r_mem [2**AW];
    logic [HIT_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port: the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/sorc_walker.sv
// Cell walker: issues one grid address per cycle along a segment.
module sorc_walker
    import sorc_pkg::*;
#(
    parameter int unsigned CW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_walk_cmd     i_cmd,
    output t_walk_stat    o_stat,
    output logic [2*CW-1:0] o_addr
);

    logic               r_active;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_rem;
    t_dir               r_dir_x;
    t_dir               r_dir_y;

    // Walk control: loaded by a command, stops after the final cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.load) begin
            r_active <= 1'b1;
        end else if (r_active && (r_rem == '0)) begin
            r_active <= 1'b0;
        end
    end

    // Position and remaining length.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_cmd.x;
            r_y     <= i_cmd.y;
            r_rem   <= i_cmd.len;
            r_dir_x <= i_cmd.dir_x;
            r_dir_y <= i_cmd.dir_y;
        end else if (r_active) begin
            r_x   <= f_step(r_x, r_dir_x);
            r_y   <= f_step(r_y, r_dir_y);
            r_rem <= r_rem - 1'b1;
        end
    end

    assign o_stat.issue = r_active;
    assign o_stat.last  = r_active && (r_rem == '0);
    assign o_addr       = {r_x[CW-1:0], r_y[CW-1:0]};

endmodule

FILE: hdl/sorc_update.sv
// Update stage: increments the counter read back from the grid and keeps the running total.
module sorc_update
    import sorc_pkg::*;
#(
    parameter int unsigned AW = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_issue,
    input  logic [AW-1:0]      i_addr,
    input  logic [HIT_W-1:0]   i_rd_data,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [HIT_W-1:0]   o_wr_data,
    output logic [COUNT_W-1:0] o_count
);

    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    logic [COUNT_W-1:0] r_count;
    logic [HIT_W-1:0]   w_hit_next;
    logic               w_count_inc;

    // Track the read in flight so its data can be matched to its address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= i_addr;
    end

    // Saturating counter increment; a cell counts once, when it first reaches two.
    always_comb begin
        w_hit_next  = i_rd_data + 1'b1;
        o_wr_en     = r_pend && (i_rd_data != HIT_MAX);
        w_count_inc = o_wr_en && (w_hit_next == HIT_OVERLAP) && (r_count != COUNT_MAX);
    end

    assign o_wr_addr = r_pend_addr;
    assign o_wr_data = w_hit_next;

    // Running overlap total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_count_inc) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_count = r_count;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the segment overlap raster counter with a grid predictor.
`timescale 1ns / 1ps

module tb_top
    import sorc_pkg::*;
();

    localparam int unsigned GRID     = GRID_SIDE_DEF;
    localparam int unsigned MAX_WAIT = 12;

    // One segment as it travels on the input channel.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_seg;

    // One result as it travels on the output channel.
    typedef struct packed {
        logic [COUNT_W-1:0] overlap_count;
        logic               bad_segment;
    } t_tally;

    // Shapes of a well-formed segment.
    typedef enum int unsigned {
        LINE_ROW,
        LINE_COL,
        LINE_RISE,
        LINE_FALL,
        LINE_DOT
    } t_line_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sorc_seg_if seg_if ();
    sorc_res_if res_if ();

    segment_overlap_raster_counter #(
        .GRID_SIDE (GRID)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state: per-cell hit counters and the running overlap total.
    bit   [HIT_W-1:0]   grid_hits [GRID*GRID];
    logic [COUNT_W-1:0] overlap_total = '0;

    t_seg   pending_segs [$];
    t_tally expected_tallies [$];

    int unsigned errors      = 0;
    int unsigned seg_count   = 0;
    int unsigned bad_count   = 0;
    int unsigned seg_gap     = 0;
    int unsigned res_wait    = 0;
    bit          seg_taken   = 1'b0;
    bit          res_taken   = 1'b0;
    bit          seg_calm    = 1'b0;
    bit          res_calm    = 1'b0;

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Draws the segment on the predicted grid and returns the expected result.
    function automatic t_tally raster_segment(t_seg s);
        int     x, y, x2, y2, dx, dy, len, step_x, step_y, idx;
        bit     bad;
        t_tally t;
        x   = int'(s.start_x);
        y   = int'(s.start_y);
        x2  = int'(s.end_x);
        y2  = int'(s.end_y);
        dx  = (x > x2) ? x - x2 : x2 - x;
        dy  = (y > y2) ? y - y2 : y2 - y;
        bad = (x >= GRID) || (y >= GRID) || (x2 >= GRID) || (y2 >= GRID) ||
              (dx != 0 && dy != 0 && dx != dy);
        if (!bad) begin
            len    = (dx > dy) ? dx : dy;
            step_x = (x2 > x) ? 1 : ((x2 < x) ? -1 : 0);
            step_y = (y2 > y) ? 1 : ((y2 < y) ? -1 : 0);
            for (int i = 0; i <= len; i++) begin
                idx = x * GRID + y;
                // A counter stops at its maximum; only the step to two counts.
                if (grid_hits[idx] != HIT_MAX) begin
                    grid_hits[idx] = grid_hits[idx] + 1'b1;
                    if (grid_hits[idx] == HIT_OVERLAP && overlap_total != COUNT_MAX)
                        overlap_total = overlap_total + 1'b1;
                end
                x += step_x;
                y += step_y;
            end
        end
        t.overlap_count = overlap_total;
        t.bad_segment   = bad;
        return t;
    endfunction

    // Builds a well-formed segment inside a square window of the given span.
    function automatic t_seg make_line(int unsigned bx, int unsigned by,
                                       int unsigned span, int unsigned maxlen);
        int unsigned len, xlen, ylen, xlo, ylo;
        t_line_kind  kind;
        t_seg        s;
        kind = t_line_kind'($urandom_range(LINE_ROW, LINE_DOT));
        len  = (kind == LINE_DOT) ? 0 : $urandom_range(0, maxlen);
        xlen = (kind == LINE_COL || kind == LINE_DOT) ? 0 : len;
        ylen = (kind == LINE_ROW || kind == LINE_DOT) ? 0 : len;
        xlo  = bx + $urandom_range(0, span - 1 - xlen);
        ylo  = by + $urandom_range(0, span - 1 - ylen);
        s.start_x = COORD_W'(xlo);
        s.end_x   = COORD_W'(xlo + xlen);
        if (kind == LINE_FALL) begin
            s.start_y = COORD_W'(ylo + ylen);
            s.end_y   = COORD_W'(ylo);
        end else begin
            s.start_y = COORD_W'(ylo);
            s.end_y   = COORD_W'(ylo + ylen);
        end
        // Walk the segment in either direction.
        if ($urandom_range(0, 1) == 1)
            s = {s.end_x, s.end_y, s.start_x, s.start_y};
        return s;
    endfunction

    task automatic queue_seg(int unsigned x1, int unsigned y1, int unsigned x2, int unsigned y2);
        pending_segs.push_back({COORD_W'(x1), COORD_W'(y1), COORD_W'(x2), COORD_W'(y2)});
    endtask

    // Holds until every queued segment has been sent and every result has returned.
    task automatic wait_drained();
        while (pending_segs.size() != 0 || seg_if.valid || expected_tallies.size() != 0)
            @(posedge i_clk);
    endtask

    // Segment driver: presents queued segments at the falling edge with random gaps.
    always @(negedge i_clk) begin
        logic v;
        t_seg nxt;
        v = seg_if.valid;
        if (!i_rst_n) begin
            v = 1'b0;
        end else begin
            if (seg_taken) begin
                seg_taken = 1'b0;
                v         = 1'b0;
                if ($urandom_range(0, 24) == 0)
                    seg_calm = !seg_calm;
                seg_gap = seg_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!v) begin
                if (seg_gap > 0) begin
                    seg_gap--;
                end else if (pending_segs.size() != 0) begin
                    nxt = pending_segs.pop_front();
                    v   = 1'b1;
                    seg_if.start_x <= nxt.start_x;
                    seg_if.start_y <= nxt.start_y;
                    seg_if.end_x   <= nxt.end_x;
                    seg_if.end_y   <= nxt.end_y;
                end
            end
        end
        seg_if.valid <= v;
    end

    // Result receiver: after each transaction it stalls for a random number of cycles.
    always @(negedge i_clk) begin
        logic r;
        r = 1'b0;
        if (i_rst_n) begin
            if (res_taken) begin
                res_taken = 1'b0;
                if ($urandom_range(0, 24) == 0)
                    res_calm = !res_calm;
                res_wait = res_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (res_wait > 0)
                res_wait--;
            else
                r = 1'b1;
        end
        res_if.ready <= r;
    end

    // Monitor: checks each result transaction, then predicts for each accepted segment.
    always @(posedge i_clk) begin
        t_tally want;
        t_seg   got_seg;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                res_taken = 1'b1;
                if (expected_tallies.size() == 0) begin
                    $error("Result transaction with no segment outstanding: overlap_count %0d",
                           res_if.overlap_count);
                    errors++;
                end else begin
                    want = expected_tallies.pop_front();
                    if (res_if.overlap_count !== want.overlap_count) begin
                        $error("overlap_count: expected %0d, got %0d",
                               want.overlap_count, res_if.overlap_count);
                        errors++;
                    end
                    if (res_if.bad_segment !== want.bad_segment) begin
                        $error("bad_segment: expected %0d, got %0d",
                               want.bad_segment, res_if.bad_segment);
                        errors++;
                    end
                end
            end
            if (seg_if.valid && seg_if.ready) begin
                seg_taken = 1'b1;
                got_seg   = {seg_if.start_x, seg_if.start_y, seg_if.end_x, seg_if.end_y};
                want      = raster_segment(got_seg);
                expected_tallies.push_back(want);
                seg_count++;
                if (want.bad_segment)
                    bad_count++;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned win_x, win_y, pick;
        seg_if.valid   = 1'b0;
        seg_if.start_x = '0;
        seg_if.start_y = '0;
        seg_if.end_x   = '0;
        seg_if.end_y   = '0;
        res_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: full-length lines along three grid edges and both diagonals.
        queue_seg(0, 0, GRID - 1, GRID - 1);
        queue_seg(0, 0, GRID - 1, 0);
        queue_seg(GRID - 1, GRID - 1, GRID - 1, 0);
        queue_seg(GRID - 1, 0, 0, GRID - 1);
        queue_seg(0, GRID - 1, 0, 0);
        // A single point on the diagonal, hit until its counter is full.
        queue_seg(500, 500, 500, 500);
        queue_seg(500, 500, 500, 500);
        queue_seg(500, 500, 500, 500);
        // A fresh single point, then the same point again.
        queue_seg(7, 300, 7, 300);
        queue_seg(7, 300, 7, 300);
        // Segments of other slopes, which must be rejected and leave the grid alone.
        queue_seg(0, 0, 1, 2);
        queue_seg(GRID - 1, GRID - 1, 0, 1);
        queue_seg(0, GRID - 1, GRID - 2, 0);
        queue_seg(5, 5, 6, 8);
        // Short diagonals and rows walked backwards, crossing each other.
        queue_seg(10, 20, 5, 15);
        queue_seg(5, 20, 10, 15);
        queue_seg(600, 3, 590, 3);
        queue_seg(595, 9, 595, 0);
        queue_seg(8, 18, 8, 12);
        wait_drained();

        // Random: mostly short lines packed into a moving window so that they overlap.
        win_x = 0;
        win_y = 0;
        for (int n = 0; n < 450; n++) begin
            if (n % 60 == 0) begin
                win_x = $urandom_range(0, GRID - 64);
                win_y = $urandom_range(0, GRID - 64);
            end
            pick = $urandom_range(0, 99);
            if (pick < 62)
                pending_segs.push_back(make_line(win_x, win_y, 64, 63));
            else if (pick < 70)
                pending_segs.push_back(make_line(0, 0, GRID, GRID - 1));
            else if (pick < 85)
                queue_seg(win_x + $urandom_range(0, 63), win_y + $urandom_range(0, 63),
                          win_x + $urandom_range(0, 63), win_y + $urandom_range(0, 63));
            else
                pending_segs.push_back(t_seg'($urandom()));
            // Let everything in flight drain once, half way through.
            if (n == 225)
                wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d segments, %0d of them rejected for slope or range.",
                 seg_count, bad_count);
        $display("The grid ended with %0d cells hit at least twice.", overlap_total);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: ends a run that hangs; the grid sweep after reset alone covers every cell of the grid.
    initial begin
        #80_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sorc_pkg.sv
hdl/sorc_intf.sv
hdl/sorc_grid_mem.sv
hdl/sorc_walker.sv
hdl/sorc_update.sv
hdl/segment_overlap_raster_counter.sv
verif/tb_top.sv
